/* hdl/ppe_pkg.sv */
`default_nettype none
package ppe_pkg;

  // Table sizes.
  localparam int MaxThresholds = 3;
  localparam int MaxTerms      = 4;
  localparam int RegionSlots   = MaxThresholds + 1;

  // Configuration register indexes.
  localparam logic CfgFracBits   = 1'b0;
  localparam logic CfgThreshInUse = 1'b1;

  // Request codes carried by the req_type field.
  typedef enum logic [1:0] {
    ReqEval   = 2'd0,
    ReqThresh = 2'd1,
    ReqCoef   = 2'd2,
    ReqCount  = 2'd3
  } req_e;

  // One word as it travels down the front of the pipeline.
  typedef struct packed {
    req_e        req;
    logic [1:0]  table_slot;
    logic [1:0]  term_slot;
    logic [63:0] x;
    logic [5:0]  d;
    logic [1:0]  n;
  } item_t;

endpackage
`default_nettype wire

/* hdl/ppe_fxmul.sv */
`default_nettype none
// Pipelined fixed-point multiply: signed 64x64 product, arithmetic shift
// right by d, low 64 bits kept. Three register stages, all held by en.
module ppe_fxmul (
  input  wire logic        clk,
  input  wire logic        en,
  input  wire logic [63:0] a,
  input  wire logic [63:0] b,
  input  wire logic [5:0]  d,
  output logic      [63:0] p
);

  logic signed [32:0]  a_hi, a_lo, b_hi, b_lo;
  logic signed [65:0]  pp_hh, pp_hl, pp_lh, pp_ll;
  logic [5:0]          d1, d2;
  logic signed [127:0] full;
  logic signed [127:0] full_next;

  // Split the operands into a signed upper and an unsigned lower half.
  assign a_hi = $signed({a[63], a[63:32]});
  assign a_lo = $signed({1'b0, a[31:0]});
  assign b_hi = $signed({b[63], b[63:32]});
  assign b_lo = $signed({1'b0, b[31:0]});

  // Stage one: four partial products.
  always_ff @(posedge clk) begin
    if (en) begin
      pp_hh <= a_hi * b_hi;
      pp_hl <= a_hi * b_lo;
      pp_lh <= a_lo * b_hi;
      pp_ll <= a_lo * b_lo;
      d1    <= d;
    end
  end

  // Stage two: assemble the full 128-bit product.
  always_comb begin
    full_next = (128'(pp_hh) <<< 64) + ((128'(pp_hl) + 128'(pp_lh)) <<< 32)
                + 128'(pp_ll);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      full <= full_next;
      d2   <= d1;
    end
  end

  // Stage three: take the 64 bits that start at the binary point.
  always_ff @(posedge clk) begin
    if (en) begin
      p <= full[d2 +: 64];
    end
  end

endmodule
`default_nettype wire

/* hdl/piecewise_poly_eval.sv */
`default_nettype none
// Piecewise polynomial evaluator on signed 64-bit fixed-point words.
//
// Request channel (req_valid / req_stall) carries one word per item: an
// evaluate request with x in data_value, or a write into the threshold,
// coefficient or term count table. Every request gives exactly one response
// word on the response channel (rsp_valid / rsp_stall): the function value
// and the region hit bits, or zeros for a table write.
// Configuration (cfg_valid / cfg_ready, always ready) sets frac_bits and
// thresholds_in_use; change it only while no request is in flight.
//
// The block is a 15-stage pipeline; one request can be taken every cycle
// while the response is not stalled. The pipeline depth is set by the
// three chained fixed-point multiplies of the power chain (three stages
// each) and the coefficient multiplies after them.
// Table writes take effect in request order at the table read stage.
// Reset empties the pipeline, clears all tables and loads frac_bits = 16,
// thresholds_in_use = 1. While the response is stalled the whole pipeline
// holds and req_stall is raised.
module piecewise_poly_eval
  import ppe_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        req_valid,
  output logic             req_stall,
  input  wire logic [1:0]  req_type,
  input  wire logic [1:0]  table_slot,
  input  wire logic [1:0]  term_slot,
  input  wire logic [63:0] data_value,
  output logic             rsp_valid,
  input  wire logic        rsp_stall,
  output logic [63:0]      y_value,
  output logic [3:0]       region_hits,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic        cfg_index,
  input  wire logic [5:0]  cfg_data
);

  localparam int LastStage = 14;
  localparam int ReadStage = 9;

  logic        en;
  logic [5:0]  frac_bits;
  logic [1:0]  thresholds_in_use;
  logic [1:0]  n_sat;

  logic        v [0:LastStage];
  item_t       pipe [0:ReadStage];

  logic [63:0] thr_tab [0:MaxThresholds-1];
  logic [63:0] coef_tab [0:RegionSlots-1][0:MaxTerms-1];
  logic [2:0]  cnt_tab [0:RegionSlots-1];

  logic [63:0] p0_0, p1_3, p2_6, p3_9;
  logic [63:0] p1q [0:5];
  logic [63:0] p2q [0:2];
  logic [63:0] pow9 [0:MaxTerms-1];
  logic [63:0] prod [0:RegionSlots-1][0:MaxTerms-1];

  logic [RegionSlots-1:0]          ind_next;
  logic [RegionSlots*MaxTerms-1:0] mask_next;
  logic [RegionSlots-1:0]          ind10, ind11, ind12, ind13;
  logic [RegionSlots*MaxTerms-1:0] mask10, mask11, mask12;
  logic [63:0] rsum_next [0:RegionSlots-1];
  logic [63:0] rsum [0:RegionSlots-1];
  logic [63:0] y_next;
  logic [63:0] y_q;
  logic [3:0]  hits_q;

  // The whole pipeline moves unless a finished word is held by the receiver.
  assign en        = !(v[LastStage] && rsp_stall);
  assign req_stall = !en;
  assign cfg_ready = 1'b1;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      frac_bits         <= 6'd16;
      thresholds_in_use <= 2'd1;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CfgFracBits:    frac_bits         <= cfg_data;
        CfgThreshInUse: thresholds_in_use <= cfg_data[1:0];
        default: ;
      endcase
    end
  end

  // Zero thresholds means one.
  assign n_sat = (thresholds_in_use == 2'd0) ? 2'd1 : thresholds_in_use;

  // Valid bits.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k <= LastStage; k++) v[k] <= 1'b0;
    end else if (en) begin
      v[0] <= req_valid;
      for (int k = 1; k <= LastStage; k++) v[k] <= v[k-1];
    end
  end

  // Request words down to the table read stage.
  always_ff @(posedge clk) begin
    if (en) begin
      pipe[0].req        <= req_e'(req_type);
      pipe[0].table_slot <= table_slot;
      pipe[0].term_slot  <= term_slot;
      pipe[0].x          <= data_value;
      pipe[0].d          <= frac_bits;
      pipe[0].n          <= n_sat;
      for (int k = 1; k <= ReadStage; k++) pipe[k] <= pipe[k-1];
    end
  end

  // Power chain: 1.0, then x, x^2 and x^3, each of the last three through one multiplier.
  assign p0_0 = 64'd1 << pipe[0].d;

  ppe_fxmul u_pow1 (.clk(clk), .en(en), .a(pipe[0].x), .b(p0_0), .d(pipe[0].d), .p(p1_3));
  ppe_fxmul u_pow2 (.clk(clk), .en(en), .a(pipe[3].x), .b(p1_3), .d(pipe[3].d), .p(p2_6));
  ppe_fxmul u_pow3 (.clk(clk), .en(en), .a(pipe[6].x), .b(p2_6), .d(pipe[6].d), .p(p3_9));

  // Delay the earlier powers to line up at the table read stage.
  always_ff @(posedge clk) begin
    if (en) begin
      p1q[0] <= p1_3;
      for (int k = 1; k < 6; k++) p1q[k] <= p1q[k-1];
      p2q[0] <= p2_6;
      for (int k = 1; k < 3; k++) p2q[k] <= p2q[k-1];
    end
  end

  assign pow9[0] = 64'd1 << pipe[ReadStage].d;
  assign pow9[1] = p1q[5];
  assign pow9[2] = p2q[2];
  assign pow9[3] = p3_9;

  // Table writes, applied in request order at the read stage.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int t = 0; t < MaxThresholds; t++) thr_tab[t] <= '0;
      for (int r = 0; r < RegionSlots; r++) begin
        cnt_tab[r] <= '0;
        for (int c = 0; c < MaxTerms; c++) coef_tab[r][c] <= '0;
      end
    end else if (en && v[ReadStage]) begin
      unique case (pipe[ReadStage].req)
        ReqThresh: begin
          if (3'(pipe[ReadStage].table_slot) < 3'(MaxThresholds))
            thr_tab[pipe[ReadStage].table_slot] <= pipe[ReadStage].x;
        end
        ReqCoef: begin
          if (3'(pipe[ReadStage].table_slot) < 3'(RegionSlots) &&
              3'(pipe[ReadStage].term_slot) < 3'(MaxTerms))
            coef_tab[pipe[ReadStage].table_slot][pipe[ReadStage].term_slot]
              <= pipe[ReadStage].x;
        end
        ReqCount: begin
          if (3'(pipe[ReadStage].table_slot) < 3'(RegionSlots))
            cnt_tab[pipe[ReadStage].table_slot] <= pipe[ReadStage].x[2:0];
        end
        ReqEval: ;
        default: ;
      endcase
    end
  end

  // Region indicators and active term masks at the read stage.
  always_comb begin
    logic [RegionSlots-1:0] below;
    logic [2:0]             cnt;
    int                     n;
    n = int'(pipe[ReadStage].n);
    below = '0;
    for (int t = 0; t < MaxThresholds; t++)
      below[t] = $signed(pipe[ReadStage].x) < $signed(thr_tab[t]);
    ind_next  = '0;
    mask_next = '0;
    for (int r = 0; r < RegionSlots; r++) begin
      if (r == 0) ind_next[r] = below[0];
      else if (r == n) ind_next[r] = !below[r-1];
      else if (r < n) ind_next[r] = !below[r-1] && below[r];
      else ind_next[r] = 1'b0;
      cnt = (cnt_tab[r] > 3'(MaxTerms)) ? 3'(MaxTerms) : cnt_tab[r];
      for (int c = 0; c < MaxTerms; c++)
        mask_next[r*MaxTerms+c] = 3'(c) < cnt;
    end
    if (pipe[ReadStage].req != ReqEval) ind_next = '0;
  end

  // One multiplier per coefficient.
  for (genvar r = 0; r < RegionSlots; r++) begin : g_reg
    for (genvar c = 0; c < MaxTerms; c++) begin : g_term
      ppe_fxmul u_term (
        .clk(clk), .en(en), .a(coef_tab[r][c]), .b(pow9[c]),
        .d(pipe[ReadStage].d), .p(prod[r][c])
      );
    end
  end

  // Carry indicators and masks alongside the term multipliers.
  always_ff @(posedge clk) begin
    if (en) begin
      ind10  <= ind_next;
      ind11  <= ind10;
      ind12  <= ind11;
      ind13  <= ind12;
      mask10 <= mask_next;
      mask11 <= mask10;
      mask12 <= mask11;
    end
  end

  // Per-region polynomial sums.
  always_comb begin
    for (int r = 0; r < RegionSlots; r++) begin
      rsum_next[r] = '0;
      for (int c = 0; c < MaxTerms; c++)
        if (mask12[r*MaxTerms+c]) rsum_next[r] = rsum_next[r] + prod[r][c];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int r = 0; r < RegionSlots; r++) rsum[r] <= rsum_next[r];
    end
  end

  // Indicator-weighted total.
  always_comb begin
    y_next = '0;
    for (int r = 0; r < RegionSlots; r++)
      if (ind13[r]) y_next = y_next + rsum[r];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      y_q    <= y_next;
      hits_q <= ind13[3:0];
    end
  end

  assign rsp_valid   = v[LastStage];
  assign y_value     = y_q;
  assign region_hits = hits_q;

  // Reset empties the pipeline.
  a_reset_empty: assert property (@(posedge clk) rst |=> !rsp_valid)
    else $error("response valid right after reset");

  // No region hit means a zero value.
  a_zero_nohit: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && region_hits == 4'd0) |-> y_value == 64'd0)
    else $error("nonzero value with no region hit");

  // The first two regions never hit together.
  a_excl01: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> !(region_hits[0] && region_hits[1]))
    else $error("regions zero and one both hit");

endmodule
`default_nettype wire
